FILE: sv/tlg_pkg.sv
// ----------------------------------------------------------------------------
// tlg_pkg: shared types and constants for the toroidal life grid stepper
// Item codes, register indexes, sequencer states and the neighborhood bundle
// passed to the rule unit.
// ----------------------------------------------------------------------------
package tlg_pkg;

   // field widths of the item and register ports
   localparam int MODE_W      = 2;
   localparam int ADDR_W      = 6;
   localparam int CFG_W       = 7;
   localparam int CSR_INDEX_W = 1;

   // item codes (unused code acts as a read)
   localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STEP   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS = 1'b1;

   // register reset values and lower clamp
   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
   localparam logic [CFG_W-1:0] CFG_MIN   = 7'd4;

   // B3/S23 rule
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_ROW_START,
      ST_LOAD_UP,
      ST_LOAD_MID,
      ST_LOAD_DN,
      ST_LOAD_LAST,
      ST_CELL,
      ST_ROW_WR,
      ST_RD_ISSUE,
      ST_RD_DATA
   } state_type;

   // one cell and its eight neighbors
   typedef struct packed {
      logic [7:0] neighbors;
      logic       alive;
   } nbhd_type;

endpackage

FILE: sv/tlg_ram.sv
// ----------------------------------------------------------------------------
// tlg_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tlg_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/tlg_rule.sv
// ----------------------------------------------------------------------------
// tlg_rule: shared neighbor count and B3/S23 rule unit
// Counts the live neighbors of one cell and gives its next state.
// ----------------------------------------------------------------------------
module tlg_rule (
   input  tlg_pkg::nbhd_type nbhd,
   output logic              next_alive
);

   logic [3:0] count;

   // population count over the eight neighbors
   always_comb begin
      count = 4'd0;
      for (int i = 0; i < 8; i++) begin
         count = count + {3'd0, nbhd.neighbors[i]};
      end
   end

   // born on three, survives on two or three
   assign next_alive = (count == tlg_pkg::BIRTH_COUNT) ||
                       (nbhd.alive && (count == tlg_pkg::SURVIVE_COUNT));

endmodule

FILE: sv/toroidal_life_grid_stepper.sv
// ----------------------------------------------------------------------------
// toroidal_life_grid_stepper: toroidal Game of Life grid, B3/S23
// Two row-wide cell banks, a small sequencer and one shared rule unit that
// evaluates one cell per cycle during a generation step.
//
//   channel   ports                                    handshake
//   request   req_start, req_mode, req_col, req_row    start & !busy
//   response  rsp_valid, rsp_cell_alive,               one-cycle strobe
//             rsp_generation_done
//   config    csr_we, csr_index, csr_wdata             write enable
//
// Toggle and read: the address is wrapped by repeated subtraction (up to 15
// subtractions for the smallest grid), then the current bank row is read.
// Step: every row of the bank is swept; an in-use row gets three row loads,
// one cell per cycle through the rule unit and one row write, an unused row
// only a row write of zeros.
// After reset both banks are cleared row by row, busy high.
// Responses are never held off: rsp_valid is high for exactly one cycle.
// ----------------------------------------------------------------------------
module toroidal_life_grid_stepper #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_start,
   output logic                               busy,
   input  logic [tlg_pkg::MODE_W-1:0]         req_mode,
   input  logic [tlg_pkg::ADDR_W-1:0]         req_col,
   input  logic [tlg_pkg::ADDR_W-1:0]         req_row,
   output logic                               rsp_valid,
   output logic                               rsp_cell_alive,
   output logic                               rsp_generation_done,
   input  logic                               csr_we,
   input  logic [tlg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tlg_pkg::CFG_W-1:0]          csr_wdata
);

   localparam int CW  = $clog2(MAX_COLS);
   localparam int RW  = $clog2(MAX_ROWS);
   localparam int RCW = (RW > tlg_pkg::CFG_W) ? RW : tlg_pkg::CFG_W;
   localparam logic [MAX_COLS-1:0] ONE_BIT = MAX_COLS'(1);

   tlg_pkg::state_type state_ff, state_in;

   logic [RW-1:0]                  y_ff, y_in;
   logic [tlg_pkg::CFG_W-1:0]      x_ff, x_in;
   logic [tlg_pkg::ADDR_W-1:0]     col_ff, col_in;
   logic [tlg_pkg::ADDR_W-1:0]     row_ff, row_in;
   logic [tlg_pkg::MODE_W-1:0]     mode_ff, mode_in;
   logic                           cur_bank_ff, cur_bank_in;
   logic [tlg_pkg::CFG_W-1:0]      cols_ff, cols_in;
   logic [tlg_pkg::CFG_W-1:0]      rows_ff, rows_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_alive_ff, rsp_alive_in;
   logic                           rsp_done_ff, rsp_done_in;
   logic [MAX_COLS-1:0]            row_up_ff, row_up_in;
   logic [MAX_COLS-1:0]            row_mid_ff, row_mid_in;
   logic [MAX_COLS-1:0]            row_dn_ff, row_dn_in;
   logic [MAX_COLS-1:0]            new_row_ff, new_row_in;

   logic [tlg_pkg::CFG_W-1:0]      eff_cols, eff_rows;
   logic [tlg_pkg::CFG_W-1:0]      y7, yu7, yd7, xl7, xr7;
   logic                           row_in_use;
   logic                           col_ge, row_ge;
   logic [RW-1:0]                  rd_addr;
   logic [MAX_COLS-1:0]            wr_data;
   logic [MAX_COLS-1:0]            rdata_a, rdata_b, src_rdata;
   logic                           we_both, we_cur, we_dst;
   logic                           we_a, we_b;
   logic                           src_bit;
   tlg_pkg::nbhd_type              nbhd;
   logic                           next_alive;

   // effective grid size, clamped to the supported range
   always_comb begin
      eff_cols = cols_ff;
      if (cols_ff < tlg_pkg::CFG_MIN) eff_cols = tlg_pkg::CFG_MIN;
      if (int'(cols_ff) > MAX_COLS) eff_cols = tlg_pkg::CFG_W'(MAX_COLS);
      eff_rows = rows_ff;
      if (rows_ff < tlg_pkg::CFG_MIN) eff_rows = tlg_pkg::CFG_MIN;
      if (int'(rows_ff) > MAX_ROWS) eff_rows = tlg_pkg::CFG_W'(MAX_ROWS);
   end

   // wrapped row and column neighbors of the sweep position
   always_comb begin
      y7         = tlg_pkg::CFG_W'(y_ff);
      row_in_use = RCW'(y_ff) < RCW'(eff_rows);
      yu7        = (y7 == '0) ? eff_rows - 7'd1 : y7 - 7'd1;
      yd7        = (y7 + 7'd1 == eff_rows) ? '0 : y7 + 7'd1;
      xl7        = (x_ff == '0) ? eff_cols - 7'd1 : x_ff - 7'd1;
      xr7        = (x_ff + 7'd1 == eff_cols) ? '0 : x_ff + 7'd1;
      col_ge     = {1'b0, col_ff} >= eff_cols;
      row_ge     = {1'b0, row_ff} >= eff_rows;
   end

   // neighborhood of the current cell from the three row registers
   always_comb begin
      nbhd.alive        = row_mid_ff[CW'(x_ff)];
      nbhd.neighbors[0] = row_up_ff[CW'(xl7)];
      nbhd.neighbors[1] = row_up_ff[CW'(x_ff)];
      nbhd.neighbors[2] = row_up_ff[CW'(xr7)];
      nbhd.neighbors[3] = row_mid_ff[CW'(xl7)];
      nbhd.neighbors[4] = row_mid_ff[CW'(xr7)];
      nbhd.neighbors[5] = row_dn_ff[CW'(xl7)];
      nbhd.neighbors[6] = row_dn_ff[CW'(x_ff)];
      nbhd.neighbors[7] = row_dn_ff[CW'(xr7)];
   end

   tlg_rule u_rule (
      .nbhd       (nbhd),
      .next_alive (next_alive)
   );

   // reads always come from the current bank
   assign src_rdata = cur_bank_ff ? rdata_b : rdata_a;
   assign src_bit   = src_rdata[CW'(col_ff)];

   // sequencer: next state, datapath updates and bank controls
   always_comb begin
      state_in     = state_ff;
      y_in         = y_ff;
      x_in         = x_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      mode_in      = mode_ff;
      cur_bank_in  = cur_bank_ff;
      rsp_valid_in = 1'b0;
      rsp_alive_in = rsp_alive_ff;
      rsp_done_in  = rsp_done_ff;
      row_up_in    = row_up_ff;
      row_mid_in   = row_mid_ff;
      row_dn_in    = row_dn_ff;
      new_row_in   = new_row_ff;
      rd_addr      = '0;
      wr_data      = new_row_ff;
      we_both      = 1'b0;
      we_cur       = 1'b0;
      we_dst       = 1'b0;

      unique case (state_ff)
         // zero both banks one row a cycle
         tlg_pkg::ST_CLEAR: begin
            wr_data = '0;
            we_both = 1'b1;
            if (y_ff == RW'(MAX_ROWS - 1)) begin
               y_in     = '0;
               state_in = tlg_pkg::ST_IDLE;
            end else begin
               y_in = y_ff + RW'(1);
            end
         end
         tlg_pkg::ST_IDLE: begin
            if (req_start) begin
               mode_in  = req_mode;
               col_in   = req_col;
               row_in   = req_row;
               state_in = tlg_pkg::ST_REDUCE;
            end
         end
         // wrap the address by repeated subtraction
         tlg_pkg::ST_REDUCE: begin
            if (col_ge) col_in = tlg_pkg::ADDR_W'({1'b0, col_ff} - eff_cols);
            if (row_ge) row_in = tlg_pkg::ADDR_W'({1'b0, row_ff} - eff_rows);
            if (!col_ge && !row_ge) begin
               if (mode_ff == tlg_pkg::MODE_STEP) begin
                  y_in     = '0;
                  state_in = tlg_pkg::ST_ROW_START;
               end else begin
                  state_in = tlg_pkg::ST_RD_ISSUE;
               end
            end
         end
         tlg_pkg::ST_ROW_START: begin
            new_row_in = '0;
            x_in       = '0;
            state_in   = row_in_use ? tlg_pkg::ST_LOAD_UP : tlg_pkg::ST_ROW_WR;
         end
         // load the rows above, at and below the sweep row
         tlg_pkg::ST_LOAD_UP: begin
            rd_addr  = RW'(yu7);
            state_in = tlg_pkg::ST_LOAD_MID;
         end
         tlg_pkg::ST_LOAD_MID: begin
            rd_addr   = RW'(y7);
            row_up_in = src_rdata;
            state_in  = tlg_pkg::ST_LOAD_DN;
         end
         tlg_pkg::ST_LOAD_DN: begin
            rd_addr    = RW'(yd7);
            row_mid_in = src_rdata;
            state_in   = tlg_pkg::ST_LOAD_LAST;
         end
         tlg_pkg::ST_LOAD_LAST: begin
            row_dn_in = src_rdata;
            state_in  = tlg_pkg::ST_CELL;
         end
         // one cell per cycle through the rule unit
         tlg_pkg::ST_CELL: begin
            new_row_in[CW'(x_ff)] = next_alive;
            if (x_ff == eff_cols - 7'd1) begin
               state_in = tlg_pkg::ST_ROW_WR;
            end else begin
               x_in = x_ff + 7'd1;
            end
         end
         // store the new row in the other bank
         tlg_pkg::ST_ROW_WR: begin
            we_dst = 1'b1;
            if (y_ff == RW'(MAX_ROWS - 1)) begin
               y_in        = '0;
               cur_bank_in = ~cur_bank_ff;
               state_in    = tlg_pkg::ST_RD_ISSUE;
            end else begin
               y_in     = y_ff + RW'(1);
               state_in = tlg_pkg::ST_ROW_START;
            end
         end
         tlg_pkg::ST_RD_ISSUE: begin
            rd_addr  = RW'(row_ff);
            state_in = tlg_pkg::ST_RD_DATA;
         end
         // report the cell, flipping it first for a toggle
         tlg_pkg::ST_RD_DATA: begin
            rsp_valid_in = 1'b1;
            rsp_done_in  = (mode_ff == tlg_pkg::MODE_STEP);
            rsp_alive_in = src_bit;
            wr_data      = src_rdata ^ (ONE_BIT << CW'(col_ff));
            if (mode_ff == tlg_pkg::MODE_TOGGLE) begin
               we_cur       = 1'b1;
               rsp_alive_in = ~src_bit;
            end
            state_in = tlg_pkg::ST_IDLE;
         end
         default: state_in = tlg_pkg::ST_IDLE;
      endcase
   end

   // configuration writes
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_we) begin
         unique case (csr_index)
            tlg_pkg::CSR_COLS: cols_in = csr_wdata;
            tlg_pkg::CSR_ROWS: rows_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // bank write enables
   assign we_a = we_both || (we_cur && !cur_bank_ff) || (we_dst && cur_bank_ff);
   assign we_b = we_both || (we_cur && cur_bank_ff) || (we_dst && !cur_bank_ff);

   tlg_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_bank_a (
      .clock   (clock),
      .wr_en   (we_a),
      .wr_addr (we_cur ? RW'(row_ff) : y_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rdata_a)
   );

   tlg_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_bank_b (
      .clock   (clock),
      .wr_en   (we_b),
      .wr_addr (we_cur ? RW'(row_ff) : y_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rdata_b)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlg_pkg::ST_CLEAR;
         y_ff         <= '0;
         cur_bank_ff  <= 1'b0;
         cols_ff      <= tlg_pkg::CFG_RESET;
         rows_ff      <= tlg_pkg::CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         y_ff         <= y_in;
         cur_bank_ff  <= cur_bank_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      mode_ff      <= mode_in;
      rsp_alive_ff <= rsp_alive_in;
      rsp_done_ff  <= rsp_done_in;
      row_up_ff    <= row_up_in;
      row_mid_ff   <= row_mid_in;
      row_dn_ff    <= row_dn_in;
      new_row_ff   <= new_row_in;
   end

   assign busy                = (state_ff != tlg_pkg::ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_alive      = rsp_alive_ff;
   assign rsp_generation_done = rsp_done_ff;

`ifndef SYNTHESIS
   // a response strobe lasts one cycle
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // an accepted request makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_start && !busy) |=> busy)
      else $error("request accepted without going busy");

   // both banks are written together only while clearing
   a_bank_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff != tlg_pkg::ST_CLEAR) |-> !(we_a && we_b))
      else $error("both banks written outside the clearing pass");

   // the reported address lies inside the grid in use
   a_addr_wrapped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlg_pkg::ST_RD_ISSUE) |->
         (({1'b0, col_ff} < eff_cols) && ({1'b0, row_ff} < eff_rows)))
      else $error("cell address not wrapped into the grid");
`endif

endmodule

FILE: test/tb_toroidal_life_grid_stepper.sv
// ----------------------------------------------------------------------------
// tb_toroidal_life_grid_stepper: self-checking bench for the life grid stepper
// A short table of hand-picked items runs first: reads after reset, corner
// cells, address wrap, out-of-range grid sizes and a blinker. Phases of random
// toggles, steps and reads on mostly small grids follow. An in-bench B3/S23
// model predicts untyped items; every response is compared field by field.
// ----------------------------------------------------------------------------
module tb_toroidal_life_grid_stepper;

   localparam int GRID_COLS   = 64;
   localparam int GRID_ROWS   = 64;
   localparam int GRID_CELLS  = GRID_COLS * GRID_ROWS;
   localparam int STALL_LIMIT = 20000;
   localparam int PHASES      = 7;
   localparam int PHASE_ITEMS = 17;
   localparam int SEED_ITEMS  = 6;
   localparam int PLAN_LEN    = 31;

   // spare item code, behaves as a read
   localparam logic [tlg_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

   typedef enum logic {PLAN_CSR, PLAN_ITEM} plan_kind_type;

   typedef struct packed {
      plan_kind_type                    kind;
      logic [tlg_pkg::CSR_INDEX_W-1:0]  index;
      logic [tlg_pkg::CFG_W-1:0]        value;
      logic [tlg_pkg::MODE_W-1:0]       mode;
      logic [tlg_pkg::ADDR_W-1:0]       col;
      logic [tlg_pkg::ADDR_W-1:0]       row;
      logic                             typed;
      logic                             alive;
      logic                             done;
   } plan_row_type;

   typedef struct packed {
      logic alive;
      logic done;
   } cell_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_start = 1'b0;
   logic [tlg_pkg::MODE_W-1:0]       req_mode = tlg_pkg::MODE_READ;
   logic [tlg_pkg::ADDR_W-1:0]       req_col = '0;
   logic [tlg_pkg::ADDR_W-1:0]       req_row = '0;
   logic                             csr_we = 1'b0;
   logic [tlg_pkg::CSR_INDEX_W-1:0]  csr_index = tlg_pkg::CSR_COLS;
   logic [tlg_pkg::CFG_W-1:0]        csr_wdata = '0;
   logic                             busy;
   logic                             rsp_valid;
   logic                             rsp_cell_alive;
   logic                             rsp_generation_done;

   // model state: two cell banks, selected bank, grid size registers
   bit                               life [2][GRID_CELLS];
   bit                               live_bank;
   logic [tlg_pkg::CFG_W-1:0]        cols_reg = tlg_pkg::CFG_RESET;
   logic [tlg_pkg::CFG_W-1:0]        rows_reg = tlg_pkg::CFG_RESET;

   cell_result_type                  expected_cells [$];
   int unsigned                      fail_count = 0;
   int unsigned                      stall_cycles = 0;
   bit                               quiet = 1'b0;
   bit                               no_idle = 1'b0;

   plan_row_type bring_up_plan [PLAN_LEN] = '{
      // cleared grid, corners, spare code
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_READ,   6'd0,  6'd0,
        1'b1, 1'b0, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, MODE_SPARE,           6'd63, 6'd63,
        1'b1, 1'b0, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_TOGGLE, 6'd0,  6'd0,
        1'b1, 1'b1, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_TOGGLE, 6'd63, 6'd63,
        1'b1, 1'b1, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_READ,   6'd63, 6'd63,
        1'b1, 1'b1, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_STEP,   6'd0,  6'd0,
        1'b0, 1'b0, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_READ,   6'd63, 6'd63,
        1'b0, 1'b0, 1'b0},
      // 5 by 5 blinker placed through wrapped addresses
      '{PLAN_CSR,  tlg_pkg::CSR_COLS, 7'd5, tlg_pkg::MODE_READ,   6'd0,  6'd0,
        1'b0, 1'b0, 1'b0},
      '{PLAN_CSR,  tlg_pkg::CSR_ROWS, 7'd5, tlg_pkg::MODE_READ,   6'd0,  6'd0,
        1'b0, 1'b0, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_TOGGLE, 6'd1,  6'd2,
        1'b0, 1'b0, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_TOGGLE, 6'd7,  6'd2,
        1'b0, 1'b0, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_TOGGLE, 6'd63, 6'd7,
        1'b0, 1'b0, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_STEP,   6'd2,  6'd1,
        1'b0, 1'b0, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_READ,   6'd2,  6'd3,
        1'b0, 1'b0, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_STEP,   6'd42, 6'd63,
        1'b0, 1'b0, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, MODE_SPARE,           6'd1,  6'd2,
        1'b0, 1'b0, 1'b0},
      // sizes below the clamp and above the maximum
      '{PLAN_CSR,  tlg_pkg::CSR_COLS, 7'd0,   tlg_pkg::MODE_READ, 6'd0,  6'd0,
        1'b0, 1'b0, 1'b0},
      '{PLAN_CSR,  tlg_pkg::CSR_ROWS, 7'd127, tlg_pkg::MODE_READ, 6'd0,  6'd0,
        1'b0, 1'b0, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_TOGGLE, 6'd63, 6'd0,
        1'b0, 1'b0, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_STEP,   6'd4,  6'd2,
        1'b0, 1'b0, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_READ,   6'd2,  6'd2,
        1'b0, 1'b0, 1'b0},
      '{PLAN_CSR,  tlg_pkg::CSR_COLS, 7'd127, tlg_pkg::MODE_READ, 6'd0,  6'd0,
        1'b0, 1'b0, 1'b0},
      '{PLAN_CSR,  tlg_pkg::CSR_ROWS, 7'd0,   tlg_pkg::MODE_READ, 6'd0,  6'd0,
        1'b0, 1'b0, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_TOGGLE, 6'd62, 6'd1,
        1'b0, 1'b0, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_STEP,   6'd1,  6'd1,
        1'b0, 1'b0, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_READ,   6'd21, 6'd42,
        1'b0, 1'b0, 1'b0},
      // smallest grid
      '{PLAN_CSR,  tlg_pkg::CSR_COLS, 7'd4, tlg_pkg::MODE_READ,   6'd0,  6'd0,
        1'b0, 1'b0, 1'b0},
      '{PLAN_CSR,  tlg_pkg::CSR_ROWS, 7'd4, tlg_pkg::MODE_READ,   6'd0,  6'd0,
        1'b0, 1'b0, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_TOGGLE, 6'd5,  6'd6,
        1'b0, 1'b0, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_STEP,   6'd0,  6'd0,
        1'b0, 1'b0, 1'b0},
      '{PLAN_ITEM, tlg_pkg::CSR_COLS, 7'd0, tlg_pkg::MODE_READ,   6'd63, 6'd62,
        1'b0, 1'b0, 1'b0}
   };

   toroidal_life_grid_stepper #(
      .MAX_COLS(GRID_COLS),
      .MAX_ROWS(GRID_ROWS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_start(req_start),
      .busy(busy),
      .req_mode(req_mode),
      .req_col(req_col),
      .req_row(req_row),
      .rsp_valid(rsp_valid),
      .rsp_cell_alive(rsp_cell_alive),
      .rsp_generation_done(rsp_generation_done),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // grid size register clamped to the legal span
   function automatic int unsigned grid_span(input logic [tlg_pkg::CFG_W-1:0] value,
                                             input int unsigned limit);
      if (value < tlg_pkg::CFG_MIN) return 32'(tlg_pkg::CFG_MIN);
      if (value > limit) return limit;
      return 32'(value);
   endfunction

   // one B3/S23 generation into the other bank, wrapping at the in-use edges
   task automatic advance_generation();
      int unsigned nc, nr, x, y, yu, yd, xl, xr, n;
      bit src, dst;
      nc = grid_span(cols_reg, GRID_COLS);
      nr = grid_span(rows_reg, GRID_ROWS);
      src = live_bank;
      dst = ~live_bank;
      for (int i = 0; i < GRID_CELLS; i++) life[dst][i] = 1'b0;
      for (y = 0; y < nr; y++) begin
         yu = (y == 0) ? nr - 1 : y - 1;
         yd = (y + 1 == nr) ? 0 : y + 1;
         for (x = 0; x < nc; x++) begin
            xl = (x == 0) ? nc - 1 : x - 1;
            xr = (x + 1 == nc) ? 0 : x + 1;
            n = 0;
            n += life[src][yu * GRID_COLS + xl];
            n += life[src][yu * GRID_COLS + x];
            n += life[src][yu * GRID_COLS + xr];
            n += life[src][y * GRID_COLS + xl];
            n += life[src][y * GRID_COLS + xr];
            n += life[src][yd * GRID_COLS + xl];
            n += life[src][yd * GRID_COLS + x];
            n += life[src][yd * GRID_COLS + xr];
            life[dst][y * GRID_COLS + x] =
               (n == tlg_pkg::BIRTH_COUNT) ||
               (life[src][y * GRID_COLS + x] && n == tlg_pkg::SURVIVE_COUNT);
         end
      end
      live_bank = dst;
   endtask

   // apply one item to the model and return the cell it reports
   task automatic predict_cell(input logic [tlg_pkg::MODE_W-1:0] mode,
                               input logic [tlg_pkg::ADDR_W-1:0] col,
                               input logic [tlg_pkg::ADDR_W-1:0] row,
                               output cell_result_type res);
      int unsigned idx;
      idx = (row % grid_span(rows_reg, GRID_ROWS)) * GRID_COLS
            + (col % grid_span(cols_reg, GRID_COLS));
      res.done = 1'b0;
      if (mode == tlg_pkg::MODE_TOGGLE) begin
         life[live_bank][idx] = ~life[live_bank][idx];
      end else if (mode == tlg_pkg::MODE_STEP) begin
         advance_generation();
         res.done = 1'b1;
      end
      res.alive = life[live_bank][idx];
   endtask

   // present one item, wait for its transfer, queue what it must return
   task automatic send_item(input logic [tlg_pkg::MODE_W-1:0] mode,
                            input logic [tlg_pkg::ADDR_W-1:0] col,
                            input logic [tlg_pkg::ADDR_W-1:0] row, input logic typed,
                            input logic alive, input logic done);
      cell_result_type res;
      req_start <= 1'b1;
      req_mode  <= mode;
      req_col   <= col;
      req_row   <= row;
      do @(negedge clock); while (busy !== 1'b0);
      predict_cell(mode, col, row, res);
      if (typed) begin
         res.alive = alive;
         res.done  = done;
      end
      expected_cells.push_back(res);
      @(posedge clock);
   endtask

   // random sender gap after a transfer
   task automatic sender_gap();
      if (!no_idle && !quiet && $urandom_range(0, 3) == 0) begin
         req_start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // register write once the block has drained
   task automatic write_register(input logic [tlg_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [tlg_pkg::CFG_W-1:0] value);
      req_start <= 1'b0;
      do @(negedge clock); while (expected_cells.size() != 0 || busy !== 1'b0);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == tlg_pkg::CSR_COLS) cols_reg = value;
      else rows_reg = value;
   endtask

   // random grid size, mostly small, sometimes clamped or full
   function automatic logic [tlg_pkg::CFG_W-1:0] pick_span();
      case ($urandom_range(0, 9))
         0: return tlg_pkg::CFG_W'($urandom_range(0, 3));
         1: return tlg_pkg::CFG_W'($urandom_range(65, 127));
         2: return tlg_pkg::CFG_W'(GRID_COLS);
         default: return tlg_pkg::CFG_W'($urandom_range(4, 12));
      endcase
   endfunction

   // response check and stall watchdog
   always @(negedge clock) begin : response_check
      cell_result_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (expected_cells.size() == 0) begin
               $error("response with nothing expected: cell_alive %0b generation_done %0b",
                      rsp_cell_alive, rsp_generation_done);
               fail_count++;
            end else begin
               want = expected_cells.pop_front();
               if (rsp_cell_alive !== want.alive) begin
                  $error("cell_alive: expected %0b, actual %0b", want.alive, rsp_cell_alive);
                  fail_count++;
               end
               if (rsp_generation_done !== want.done) begin
                  $error("generation_done: expected %0b, actual %0b",
                         want.done, rsp_generation_done);
                  fail_count++;
               end
            end
         end
         if (rsp_valid === 1'b1 || (req_start && busy === 1'b0)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned cspan, rspan, pick;
      logic [tlg_pkg::MODE_W-1:0] mode;
      logic [tlg_pkg::ADDR_W-1:0] col, row;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (bring_up_plan[i]) begin
         if (bring_up_plan[i].kind == PLAN_CSR) begin
            write_register(bring_up_plan[i].index, bring_up_plan[i].value);
         end else begin
            send_item(bring_up_plan[i].mode, bring_up_plan[i].col, bring_up_plan[i].row,
                      bring_up_plan[i].typed, bring_up_plan[i].alive, bring_up_plan[i].done);
            sender_gap();
         end
      end

      // random phases: seed a pattern, then mix steps, reads and more toggles
      for (int p = 0; p < PHASES; p++) begin
         no_idle = (p == PHASES - 1);
         write_register(tlg_pkg::CSR_COLS, (p == 2) ? tlg_pkg::CFG_RESET : pick_span());
         write_register(tlg_pkg::CSR_ROWS, (p == 2) ? tlg_pkg::CFG_RESET : pick_span());
         cspan = grid_span(cols_reg, GRID_COLS);
         rspan = grid_span(rows_reg, GRID_ROWS);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 7 == 0) quiet = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (k < SEED_ITEMS) mode = (pick < 80) ? tlg_pkg::MODE_TOGGLE : tlg_pkg::MODE_READ;
            else if (pick < 30) mode = tlg_pkg::MODE_TOGGLE;
            else if (pick < 55) mode = tlg_pkg::MODE_STEP;
            else if (pick < 90) mode = tlg_pkg::MODE_READ;
            else mode = MODE_SPARE;
            col = ($urandom_range(0, 3) == 0) ? tlg_pkg::ADDR_W'($urandom_range(0, 63))
                                              : tlg_pkg::ADDR_W'($urandom_range(0, cspan - 1));
            row = ($urandom_range(0, 3) == 0) ? tlg_pkg::ADDR_W'($urandom_range(0, 63))
                                              : tlg_pkg::ADDR_W'($urandom_range(0, rspan - 1));
            send_item(mode, col, row, 1'b0, 1'b0, 1'b0);
            sender_gap();
         end
      end

      // drain
      req_start <= 1'b0;
      do @(negedge clock); while (expected_cells.size() != 0);
      repeat (64) @(negedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
